>>> rtl/core/first_fit_extent_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_macros
// Assertion macros for the extent allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFEA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFEA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFEA_ASSERT(label, clk, rst_n, prop, msg)
`define FFEA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/ffea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffea_pkg
// Types and constants shared by the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam int unsigned DefMaxExtents = 128;
  localparam int unsigned DefFrameBits  = 20;
  localparam int unsigned FrameBits     = DefFrameBits;
  localparam int unsigned CountBits     = FrameBits + 1;
  localparam int unsigned CfgIdxBits    = 1;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  localparam logic [CfgIdxBits-1:0] CFG_REGION_FIRST = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_REGION_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]           mode;
    logic [FrameBits-1:0] first_frame;
    logic [CountBits-1:0] frame_count;
  } req_t;

  typedef struct packed {
    logic [FrameBits-1:0] granted_frame;
    logic [1:0]           status;
  } rsp_t;

endpackage

>>> rtl/core/ffea_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffea_table
// Extent table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffea_table #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 41,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/first_fit_extent_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit free-list allocator over a sorted table of free frame extents.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low, and its single
// result beat appears on rsp_o for one cycle with done_o high; the receiver
// cannot stall it. The extent table is one memory with one read and one write
// port, walked one entry at a time. Init answers in the cycle after it is
// accepted. Allocate and release read each extent they look at through S_RD
// and S_CHK. Removing or inserting an entry moves each shifted entry through
// S_SHRD and S_SHWR; an insert that moves entries ends in S_MRG2, and a release
// that merges downward while a higher extent exists passes through S_MRG. The
// next command is taken after the result beat.
`include "first_fit_extent_allocator_macros.svh"

module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int unsigned MaxExtents = DefMaxExtents
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CountBits-1:0]  cfg_data_i
);

  localparam int unsigned AW = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;
  localparam int unsigned TW = $clog2(MaxExtents + 1);
  localparam int unsigned EW = FrameBits + CountBits;
  localparam logic [FrameBits+1:0] Space = {2'b01, {FrameBits{1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RD    = 8'b00000010,
    S_CHK   = 8'b00000100,
    S_SHRD  = 8'b00001000,
    S_SHWR  = 8'b00010000,
    S_RSP   = 8'b00100000,
    S_MRG   = 8'b01000000,
    S_MRG2  = 8'b10000000
  } state_e;

  state_e                 state_q, state_d;
  logic [FrameBits-1:0]   reg_first_q;
  logic [CountBits-1:0]   reg_count_q;
  logic [TW-1:0]          total_q, total_d;
  logic [TW-1:0]          idx_q, idx_d;
  logic [TW-1:0]          ptr_q, ptr_d;
  logic                   dir_up_q, dir_up_d;
  logic [1:0]             mode_q;
  logic [FrameBits-1:0]   first_q;
  logic [CountBits-1:0]   count_q, count_d;
  logic [FrameBits-1:0]   grant_q, grant_d;
  status_e                status_q, status_d;
  logic                   prev_ok_q, prev_ok_d;
  logic [FrameBits-1:0]   pbase_q, pbase_d;
  logic [CountBits-1:0]   psize_q, psize_d;
  logic [EW-1:0]          pend_data_q, pend_data_d;
  logic [TW-1:0]          fin_idx_q, fin_idx_d;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [EW-1:0]          wdata, rdata;
  logic [TW-1:0]          raddr_w;
  logic [FrameBits-1:0]   rbase;
  logic [CountBits-1:0]   rsize;
  logic [FrameBits+1:0]   room_in, room_cfg, pend_end, rel_end;
  logic [CountBits-1:0]   clip_in, clip_cfg;

  assign rbase = rdata[EW-1:CountBits];
  assign rsize = rdata[CountBits-1:0];

  // Adders: end of the previous extent, end of the release, room in space.
  assign pend_end = {2'b00, pbase_q} + {1'b0, psize_q};
  assign rel_end  = {2'b00, first_q} + {1'b0, count_q};
  assign room_in  = Space - {2'b00, req_i.first_frame};
  assign room_cfg = Space - {2'b00, reg_first_q};
  assign clip_in  = ({1'b0, req_i.frame_count} > room_in) ?
                    room_in[CountBits-1:0] : req_i.frame_count;
  assign clip_cfg = ({1'b0, reg_count_q} > room_cfg) ?
                    room_cfg[CountBits-1:0] : reg_count_q;

  ffea_table #(.Depth(MaxExtents), .Width(EW)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_first_q <= '0;
      reg_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REGION_FIRST: reg_first_q <= cfg_data_i[FrameBits-1:0];
        CFG_REGION_COUNT: reg_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    dir_up_d    = dir_up_q;
    count_d     = count_q;
    grant_d     = grant_q;
    status_d    = status_q;
    prev_ok_d   = prev_ok_q;
    pbase_d     = pbase_q;
    psize_d     = psize_q;
    pend_data_d = pend_data_q;
    fin_idx_d   = fin_idx_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr_w     = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d     = '0;
          grant_d   = '0;
          status_d  = ST_OK;
          prev_ok_d = 1'b0;
          count_d   = (req_i.mode == MODE_RELEASE) ? clip_in : req_i.frame_count;
          raddr_w   = '0;
          unique case (req_i.mode)
            MODE_INIT: begin
              total_d = '0;
              if (clip_cfg != '0) begin
                we      = 1'b1;
                wdata   = {reg_first_q, clip_cfg};
                total_d = TW'(1);
              end
              state_d = S_RSP;
            end
            MODE_ALLOC: begin
              state_d = S_RD;
            end
            MODE_RELEASE: begin
              state_d = (clip_in == '0) ? S_RSP : S_RD;
            end
            default: state_d = S_RSP;
          endcase
        end
      end
      S_RD: begin
        // Read of entry idx_q is in flight.
        state_d = S_CHK;
      end
      S_CHK: begin
        if (mode_q == MODE_ALLOC) begin
          if (idx_q >= total_q) begin
            status_d = ST_NOFIT;
            state_d  = S_RSP;
          end else if (rsize >= count_q) begin
            grant_d = rbase;
            if (rsize == count_q) begin
              if (count_q == '0) begin
                state_d = S_RSP;
              end else begin
                dir_up_d = 1'b0;
                ptr_d    = idx_q;
                total_d  = total_q - TW'(1);
                raddr_w  = idx_q + TW'(1);
                state_d  = (idx_q + TW'(1) < total_q) ? S_SHRD : S_RSP;
              end
            end else begin
              we    = 1'b1;
              waddr = idx_q[AW-1:0];
              wdata = {FrameBits'(rbase + count_q[FrameBits-1:0]), rsize - count_q};
              state_d = S_RSP;
            end
          end else begin
            idx_d   = idx_q + TW'(1);
            raddr_w = idx_q + TW'(1);
            state_d = S_RD;
          end
        end else begin
          if (idx_q < total_q && rbase < first_q) begin
            prev_ok_d = 1'b1;
            pbase_d   = rbase;
            psize_d   = rsize;
            idx_d     = idx_q + TW'(1);
            raddr_w   = idx_q + TW'(1);
            state_d   = S_RD;
          end else if (prev_ok_q && pend_end == {2'b00, first_q}) begin
            psize_d = psize_q + count_q;
            we      = 1'b1;
            waddr   = AW'(idx_q - TW'(1));
            wdata   = {pbase_q, psize_q + count_q};
            state_d = (idx_q < total_q) ? S_MRG : S_RSP;
          end else if (idx_q < total_q && rel_end == {2'b00, rbase}) begin
            we      = 1'b1;
            waddr   = idx_q[AW-1:0];
            wdata   = {first_q, rsize + count_q};
            state_d = S_RSP;
          end else if (total_q >= TW'(MaxExtents)) begin
            status_d = ST_FULL;
            state_d  = S_RSP;
          end else begin
            total_d   = total_q + TW'(1);
            fin_idx_d = idx_q;
            if (idx_q == total_q) begin
              we      = 1'b1;
              waddr   = idx_q[AW-1:0];
              wdata   = {first_q, count_q};
              state_d = S_RSP;
            end else begin
              dir_up_d    = 1'b1;
              ptr_d       = total_q;
              raddr_w     = total_q - TW'(1);
              pend_data_d = {first_q, count_q};
              state_d     = S_SHRD;
            end
          end
        end
      end
      S_MRG: begin
        // Entry idx_q is still on the read port; test the upper merge.
        if ({2'b00, pbase_q} + {1'b0, psize_q} == {2'b00, rbase}) begin
          we      = 1'b1;
          waddr   = AW'(idx_q - TW'(1));
          wdata   = {pbase_q, psize_q + rsize};
          dir_up_d = 1'b0;
          ptr_d    = idx_q;
          total_d  = total_q - TW'(1);
          raddr_w  = idx_q + TW'(1);
          state_d  = (idx_q + TW'(1) < total_q) ? S_SHRD : S_RSP;
        end else begin
          state_d = S_RSP;
        end
      end
      S_SHRD: begin
        raddr_w = dir_up_q ? ptr_q - TW'(1) : ptr_q + TW'(1);
        state_d = S_SHWR;
      end
      S_SHWR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
        wdata = rdata;
        if (dir_up_q) begin
          ptr_d   = ptr_q - TW'(1);
          raddr_w = ptr_q - TW'(2);
          if (ptr_q - TW'(1) == fin_idx_q) begin
            state_d = S_MRG2;
          end else begin
            state_d = S_SHRD;
          end
        end else begin
          ptr_d   = ptr_q + TW'(1);
          raddr_w = ptr_q + TW'(2);
          state_d = (ptr_q + TW'(1) < total_q) ? S_SHRD : S_RSP;
        end
      end
      S_MRG2: begin
        we      = 1'b1;
        waddr   = fin_idx_q[AW-1:0];
        wdata   = pend_data_q;
        state_d = S_RSP;
      end
      S_RSP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign raddr = raddr_w[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      prev_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      prev_ok_q <= prev_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    ptr_q       <= ptr_d;
    dir_up_q    <= dir_up_d;
    count_q     <= count_d;
    grant_q     <= grant_d;
    status_q    <= status_d;
    pbase_q     <= pbase_d;
    psize_q     <= psize_d;
    pend_data_q <= pend_data_d;
    fin_idx_q   <= fin_idx_d;
    if (state_q == S_IDLE && start_i) begin
      mode_q  <= req_i.mode;
      first_q <= req_i.first_frame;
    end
  end

  assign busy_o              = (state_q != S_IDLE);
  assign done_o              = (state_q == S_RSP);
  assign rsp_o.granted_frame = grant_q;
  assign rsp_o.status        = status_q;

  `FFEA_ASSERT(a_total_bound, clk_i, rst_ni, total_q <= TW'(MaxExtents), "extent count over depth")
  `FFEA_ASSERT(a_done_once, clk_i, rst_ni, done_o |=> !done_o, "result beat longer than one cycle")
  `FFEA_ASSERT(a_full_status, clk_i, rst_ni, (done_o && status_q == ST_FULL) |-> total_q == TW'(MaxExtents), "full status with room left")
  `FFEA_ASSERT(a_grant_zero, clk_i, rst_ni, (done_o && status_q != ST_OK) |-> grant_q == '0, "failed beat carries a frame")
  `FFEA_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |=> !busy_o || $past(rst_ni), "busy right after reset")

endmodule

>>> bench/tb_first_fit_extent_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_extent_allocator
// Self-checking bench for the first-fit extent allocator.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the free-extent table and predicts every
// answer at the moment a command is accepted. Each result beat is checked
// against the oldest prediction. Stimulus starts with directed corner cases.
// It then runs phases of allocate and release traffic, with some noise mixed
// in, and phases that fill the table to its limit. Region registers are only
// rewritten between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_first_fit_extent_allocator;
  import ffea_pkg::*;

  localparam int unsigned Slots = DefMaxExtents;
  localparam longint FrameSpace = longint'(1) << FrameBits;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ItemGoal = 1050;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CountBits-1:0] cfg_data_i = '0;

  first_fit_extent_allocator dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Table copy 0 tracks accepted commands, copy 1 runs ahead at generation.
  logic [FrameBits-1:0] free_base[2][Slots];
  logic [CountBits-1:0] free_len[2][Slots];
  int unsigned free_cnt[2];
  logic [FrameBits-1:0] region_first = '0;
  logic [CountBits-1:0] region_count = '0;

  req_t cmd_q[$];
  rsp_t answer_q[$];
  logic [FrameBits-1:0] held_base[$];
  logic [CountBits-1:0] held_len[$];

  int unsigned mismatches = 0;
  int unsigned accepted_cmds = 0;
  int unsigned checked_beats = 0;
  int unsigned full_seen = 0;
  int unsigned nofit_seen = 0;
  int unsigned items_made = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  bit steady = 1'b0;

  function automatic longint clip_len(longint first, longint len);
    longint room;
    room = FrameSpace - first;
    return (len > room) ? room : len;
  endfunction

  function automatic void drop_extent(int c, int unsigned i);
    for (int unsigned k = i; k + 1 < free_cnt[c]; k++) begin
      free_base[c][k] = free_base[c][k+1];
      free_len[c][k] = free_len[c][k+1];
    end
    if (free_cnt[c] > 0) free_cnt[c]--;
  endfunction

  function automatic rsp_t predict_answer(int c, req_t r);
    rsp_t a;
    longint first, len, n;
    int unsigned i;
    bit taken;
    a = '0;
    a.status = ST_OK;
    first = longint'(r.first_frame);
    n = longint'(r.frame_count);
    case (mode_e'(r.mode))
      MODE_INIT: begin
        len = clip_len(longint'(region_first), longint'(region_count));
        free_cnt[c] = 0;
        if (len != 0) begin
          free_base[c][0] = region_first;
          free_len[c][0] = CountBits'(len);
          free_cnt[c] = 1;
        end
      end
      MODE_ALLOC: begin
        taken = 1'b0;
        a.status = ST_NOFIT;
        for (i = 0; i < free_cnt[c] && !taken; i++) begin
          if (longint'(free_len[c][i]) >= n) begin
            taken = 1'b1;
            a.granted_frame = free_base[c][i];
            a.status = ST_OK;
            if (longint'(free_len[c][i]) == n) begin
              drop_extent(c, i);
            end else begin
              free_base[c][i] = FrameBits'(longint'(free_base[c][i]) + n);
              free_len[c][i] = CountBits'(longint'(free_len[c][i]) - n);
            end
          end
        end
      end
      MODE_RELEASE: begin
        len = clip_len(first, n);
        if (len != 0) begin
          i = 0;
          while (i < free_cnt[c] && longint'(free_base[c][i]) < first) i++;
          if (i > 0 && longint'(free_base[c][i-1]) + longint'(free_len[c][i-1]) == first)
          begin
            free_len[c][i-1] = CountBits'(longint'(free_len[c][i-1]) + len);
            if (i < free_cnt[c] && longint'(free_base[c][i-1]) +
                longint'(free_len[c][i-1]) == longint'(free_base[c][i])) begin
              free_len[c][i-1] = CountBits'(longint'(free_len[c][i-1]) +
                                            longint'(free_len[c][i]));
              drop_extent(c, i);
            end
          end else if (i < free_cnt[c] && first + len == longint'(free_base[c][i])) begin
            free_base[c][i] = r.first_frame;
            free_len[c][i] = CountBits'(longint'(free_len[c][i]) + len);
          end else if (free_cnt[c] >= Slots) begin
            a.status = ST_FULL;
          end else begin
            for (int unsigned k = free_cnt[c]; k > i; k--) begin
              free_base[c][k] = free_base[c][k-1];
              free_len[c][k] = free_len[c][k-1];
            end
            free_base[c][i] = r.first_frame;
            free_len[c][i] = CountBits'(len);
            free_cnt[c]++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic queue_cmd(mode_e m, longint first, longint n);
    req_t r;
    rsp_t a;
    r.mode = m;
    r.first_frame = FrameBits'(first);
    r.frame_count = CountBits'(n);
    a = predict_answer(1, r);
    if (m == MODE_ALLOC && a.status == ST_OK && r.frame_count != 0) begin
      held_base.push_back(a.granted_frame);
      held_len.push_back(r.frame_count);
    end
    if (m == MODE_INIT) begin
      held_base.delete();
      held_len.delete();
    end
    cmd_q.push_back(r);
    items_made++;
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || answer_q.size() != 0 || start_i) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, longint value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CountBits'(value);
    if (idx == CFG_REGION_FIRST) region_first = FrameBits'(value);
    else region_count = CountBits'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_region(longint first, longint n);
    wait_idle();
    write_reg(CFG_REGION_FIRST, first);
    write_reg(CFG_REGION_COUNT, n);
  endtask

  task automatic fill_table();
    int unsigned order[Slots + 4];
    int unsigned j, t;
    longint stride;
    stride = 2 + $urandom_range(0, 3);
    set_region(0, 0);
    queue_cmd(MODE_INIT, 0, 0);
    foreach (order[k]) order[k] = k;
    foreach (order[k]) begin
      j = $urandom_range(0, Slots + 3);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    foreach (order[k]) queue_cmd(MODE_RELEASE, order[k] * stride + 7, 1);
    for (int k = 0; k < 6; k++) queue_cmd(MODE_ALLOC, 0, $urandom_range(1, 2));
  endtask

  task automatic j_release();
    int unsigned j;
    j = $urandom_range(0, held_base.size() - 1);
    queue_cmd(MODE_RELEASE, held_base[j], held_len[j]);
    held_base.delete(j);
    held_len.delete(j);
  endtask

  task automatic traffic_phase();
    int unsigned pick, len;
    longint first, n;
    first = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, FrameSpace - 1))
                                        : longint'($urandom_range(0, 4096));
    case ($urandom_range(0, 5))
      0: n = FrameSpace;
      1: n = longint'($urandom_range(0, (1 << CountBits) - 1));
      default: n = longint'($urandom_range(64, 4096));
    endcase
    set_region(first, n);
    steady = ($urandom_range(0, 3) == 0);
    queue_cmd(MODE_INIT, 0, 0);
    len = $urandom_range(30, 80);
    for (int unsigned k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        n = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, (1 << CountBits) - 1))
                                        : longint'($urandom_range(1, 48));
        queue_cmd(MODE_ALLOC, $urandom_range(0, FrameSpace - 1), n);
      end else if (pick < 16 && held_base.size() != 0) begin
        j_release();
      end else if (pick < 18) begin
        queue_cmd(MODE_RELEASE, $urandom_range(0, FrameSpace - 1),
                  ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, (1 << CountBits) - 1))
                                              : longint'($urandom_range(0, 8)));
      end else begin
        queue_cmd(mode_e'($urandom_range(0, 3)), $urandom_range(0, FrameSpace - 1),
                  $urandom_range(0, (1 << CountBits) - 1));
      end
    end
  endtask

  // Driver: presents queued commands, with random gaps between them unless steady.
  always @(posedge clk_i or negedge rst_ni) begin
    bit nxt_start;
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left <= 0;
    end else begin
      nxt_start = start_i;
      if (start_i && !busy_o) begin
        answer_q.push_back(predict_answer(0, req_i));
        void'(cmd_q.pop_front());
        accepted_cmds++;
        nxt_start = 1'b0;
        if (!steady) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left <= 0;
            9: gap_left <= $urandom_range(20, 80);
            default: gap_left <= $urandom_range(1, 3);
          endcase
        end
      end else if (!start_i && gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (!start_i && cmd_q.size() != 0) begin
        nxt_start = 1'b1;
        req_i <= cmd_q[0];
      end
      start_i <= nxt_start;
    end
  end

  // Monitor: one result beat per done strobe, checked in order.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", rsp_o);
      end else begin
        want = answer_q.pop_front();
        checked_beats++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_NOFIT) nofit_seen++;
        if (rsp_o.granted_frame !== want.granted_frame || rsp_o.status !== want.status)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: granted %0d status %0d, expected %0d status %0d",
                     rsp_o.granted_frame, rsp_o.status, want.granted_frame, want.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout with %0d results outstanding", answer_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_region(0, FrameSpace);
    queue_cmd(MODE_ALLOC, 0, 0);
    queue_cmd(MODE_INIT, 0, 0);
    queue_cmd(MODE_ALLOC, 0, 0);
    queue_cmd(MODE_ALLOC, 0, FrameSpace + 1);
    queue_cmd(MODE_ALLOC, 0, FrameSpace);
    queue_cmd(MODE_ALLOC, 0, 1);
    queue_cmd(MODE_RELEASE, FrameSpace - 1, (1 << CountBits) - 1);
    queue_cmd(MODE_RELEASE, 0, 0);
    queue_cmd(MODE_RELEASE, 0, 16);
    queue_cmd(MODE_RELEASE, 32, 16);
    queue_cmd(MODE_RELEASE, 16, 16);
    queue_cmd(MODE_ALLOC, 0, 48);
    queue_cmd(MODE_RELEASE, 100, 10);
    queue_cmd(MODE_RELEASE, 90, 10);
    queue_cmd(MODE_NONE, FrameSpace - 1, (1 << CountBits) - 1);
    set_region(FrameSpace - 1, (1 << CountBits) - 1);
    queue_cmd(MODE_INIT, 0, 0);
    queue_cmd(MODE_ALLOC, 0, 2);
    queue_cmd(MODE_ALLOC, 0, 1);
    set_region(12345, 0);
    queue_cmd(MODE_INIT, 0, 0);
    queue_cmd(MODE_ALLOC, 0, 1);

    fill_table();
    while (items_made < ItemGoal) begin
      if ($urandom_range(0, 11) == 0) fill_table();
      else traffic_phase();
    end

    wait_idle();
    repeat (600) @(posedge clk_i);
    $display("Ran %0d commands and checked %0d result beats over varied regions.",
             accepted_cmds, checked_beats);
    $display("Saw %0d no-fit answers and %0d table-full answers.", nofit_seen, full_seen);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
